// File: rtl/key_sequence_matcher_unit_defines.svh
// Assertion macros shared by the key sequence matcher RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef KEY_SEQUENCE_MATCHER_UNIT_DEFINES_SVH
`define KEY_SEQUENCE_MATCHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, held off during reset
`define KSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define KSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KSM_ASSERT_IMPL(label, ante, cons, msg)
`define KSM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/ksm_pkg.sv
// Types, codes and defaults for the key sequence matcher.
// No dependencies; used by ksm_search and the top level.
package ksm_pkg;

    localparam int MAX_SEQ_LEN_DEF  = 4;
    localparam int DICT_ENTRIES_DEF = 32;
    localparam int KEY_W            = 16;
    localparam int ENTRY_FIELD_W    = 5;
    localparam int SLOT_FIELD_W     = 3;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_LEAD_LOW  = 2'd1;
    localparam logic [1:0] REG_LEAD_HIGH = 2'd2;

    localparam logic [7:0] TIMEOUT_RESET = 8'd80;

    typedef struct packed {
        logic [1:0]               operation;
        logic [KEY_W-1:0]         key_code;
        logic                     pressed_now;
        logic                     pressed_before;
        logic                     injected_event;
        logic                     post_clear;
        logic [ENTRY_FIELD_W-1:0] entry_index;
        logic [SLOT_FIELD_W-1:0]  slot_index;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0]         out_key;
        logic                     action_fired;
        logic [ENTRY_FIELD_W-1:0] action_entry;
    } result_t;

    typedef struct packed {
        logic go;
        logic exact;
    } srch_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } srch_rsp_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_WAIT
    } ctl_state_t;

    typedef enum logic {
        SRCH_IDLE,
        SRCH_SCAN
    } srch_state_t;

endpackage

// File: rtl/ksm_dict_ram.sv
// Dictionary word store: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
module ksm_dict_ram #(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/ksm_search.sv
// Dictionary scan sequencer: one word compare per cycle against the typed keys.
// Depends on ksm_pkg and the assertion macros; drives the read port of ksm_dict_ram.
`include "key_sequence_matcher_unit_defines.svh"
module ksm_search #(
    parameter int MAX_SEQ_LEN  = ksm_pkg::MAX_SEQ_LEN_DEF,
    parameter int DICT_ENTRIES = ksm_pkg::DICT_ENTRIES_DEF,
    parameter int CNT_W        = $clog2(MAX_SEQ_LEN + 1),
    parameter int ENT_W        = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1,
    parameter int ADDR_W       = $clog2(DICT_ENTRIES * (MAX_SEQ_LEN + 1))
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ksm_pkg::srch_req_t                        req,
    input  logic [MAX_SEQ_LEN:0][ksm_pkg::KEY_W-1:0]  typed_keys,
    input  logic [CNT_W-1:0]                          typed_count,
    output ksm_pkg::srch_rsp_t                        rsp,
    output logic [ENT_W-1:0]                          hit_entry,
    output logic [ADDR_W-1:0]                         rd_addr,
    input  logic [ksm_pkg::KEY_W-1:0]                 rd_data
);

    import ksm_pkg::*;

    localparam int ENTRY_WORDS = MAX_SEQ_LEN + 1;
    localparam int SLOT_W      = $clog2(MAX_SEQ_LEN + 2);

    srch_state_t       state_reg, state_next;
    logic [ENT_W-1:0]  e_reg, e_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              exact_reg, exact_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [ENT_W-1:0]  hit_entry_reg, hit_entry_next;

    logic [SLOT_W-1:0] count_ext;
    logic              s_in_seq;
    logic [KEY_W-1:0]  operand;
    logic              word_eq;
    logic              last_entry;
    logic              fin;
    logic              fin_hit;
    logic [SLOT_W-1:0] s_inc;

    assign count_ext  = SLOT_W'(typed_count);
    assign s_in_seq   = (s_reg <= count_ext);
    assign operand    = s_in_seq ? typed_keys[s_reg[CNT_W-1:0]] : '0;
    assign word_eq    = (rd_data == operand);
    assign last_entry = (e_reg == ENT_W'(DICT_ENTRIES - 1));
    assign s_inc      = s_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SRCH_IDLE:
            begin
                if (req.go)
                begin
                    state_next = SRCH_SCAN;
                end
            end
            SRCH_SCAN:
            begin
                if (fin)
                begin
                    state_next = SRCH_IDLE;
                end
            end
            default:
            begin
                state_next = SRCH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fin            = 1'b0;
        fin_hit        = 1'b0;
        e_next         = e_reg;
        s_next         = s_reg;
        base_next      = base_reg;
        exact_next     = exact_reg;
        rd_addr        = base_reg;
        unique case (state_reg)
            SRCH_IDLE:
            begin
                if (req.go)
                begin
                    e_next     = '0;
                    s_next     = '0;
                    base_next  = '0;
                    exact_next = req.exact;
                    rd_addr    = '0;
                end
            end
            SRCH_SCAN:
            begin
                if ((s_reg == '0) && (rd_data == '0))
                begin
                    fin = 1'b1;
                end
                else if (!word_eq)
                begin
                    if (last_entry)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        e_next    = e_reg + 1'b1;
                        s_next    = '0;
                        base_next = base_reg + ADDR_W'(ENTRY_WORDS);
                        rd_addr   = base_next;
                    end
                end
                else if (s_in_seq && (s_reg == count_ext)
                         && (!exact_reg || (typed_count == CNT_W'(MAX_SEQ_LEN))))
                begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                end
                else if (!s_in_seq)
                begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                end
                else
                begin
                    s_next  = s_inc;
                    rd_addr = base_reg + ADDR_W'(s_inc);
                end
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase
        done_next      = fin;
        hit_next       = fin & fin_hit;
        hit_entry_next = fin_hit ? e_reg : hit_entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SRCH_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg         <= e_next;
        s_reg         <= s_next;
        base_reg      <= base_next;
        exact_reg     <= exact_next;
        hit_entry_reg <= hit_entry_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.hit   = hit_reg;
    assign hit_entry = hit_entry_reg;

    `KSM_ASSERT_IMPL(a_go_when_idle, req.go, state_reg == SRCH_IDLE, "scan restarted while running")
    `KSM_ASSERT_IMPL(a_hit_with_done, hit_reg, done_reg, "hit flagged without done")
    `KSM_ASSERT_NEXT(a_fin_done, (state_reg == SRCH_SCAN) && fin, done_reg && (state_reg == SRCH_IDLE), "scan end not reported")

endmodule

// File: rtl/key_sequence_matcher_unit.sv
// Leader-key sequence matcher top level: command port, APB registers, sequence state.
// Depends on ksm_pkg, ksm_dict_ram, ksm_search and the assertion macros.
//
// An item is taken when start is high and busy is low. Dictionary writes, ticks and key
// events that need no lookup give their result on done from the execute state. A key
// press that extends the sequence, and a key release on an active sequence, scan the
// dictionary one word per cycle through the single word comparator and the dictionary's
// one read port; their result comes from the wait state when the scan ends. Every item
// gives exactly one result, shown on result for the one cycle that done is high; it
// cannot be held off, so the receiver must take it in that cycle. Registers must be
// written over APB only while the block is idle; the block itself does not enforce it.
`include "key_sequence_matcher_unit_defines.svh"
module key_sequence_matcher_unit #(
    parameter int MAX_SEQ_LEN  = ksm_pkg::MAX_SEQ_LEN_DEF,
    parameter int DICT_ENTRIES = ksm_pkg::DICT_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ksm_pkg::item_t                item,
    output logic                          done,
    output ksm_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ksm_pkg::PADDR_W-1:0]   paddr,
    input  logic [ksm_pkg::PDATA_W-1:0]   pwdata,
    output logic [ksm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import ksm_pkg::*;

    localparam int ENTRY_WORDS = MAX_SEQ_LEN + 1;
    localparam int DEPTH       = DICT_ENTRIES * ENTRY_WORDS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(MAX_SEQ_LEN + 1);
    localparam int ENT_W       = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

    ctl_state_t state_reg, state_next;
    item_t      item_reg, item_next;
    result_t    result_reg, result_next;
    logic       done_reg, done_next;

    logic [MAX_SEQ_LEN:0][KEY_W-1:0] typed_keys_reg, typed_keys_next;
    logic [CNT_W-1:0]                typed_count_reg, typed_count_next;
    logic [7:0]                      idle_reg, idle_next;

    logic [7:0]       timeout_reg;
    logic [KEY_W-1:0] lead_low_reg;
    logic [KEY_W-1:0] lead_high_reg;

    srch_req_t         srch_req;
    srch_rsp_t         srch_rsp;
    logic [ENT_W-1:0]  srch_entry;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic             accept;
    logic             active;
    logic             leader;
    logic             key_live;
    logic             do_append;
    logic             do_release;
    logic             launch;
    logic [CNT_W-1:0] count_inc;
    logic [7:0]       idle_inc;
    logic             wr_ok;
    logic [ENT_W+ENTRY_FIELD_W-1:0] entry_wide;
    logic             cfg_wr;

    assign accept   = start && !busy;
    assign busy     = (state_reg != CTL_IDLE);
    assign active   = (typed_keys_reg[0] != '0);
    assign leader   = (item_reg.key_code >= lead_low_reg) && (item_reg.key_code <= lead_high_reg);
    assign key_live = (item_reg.operation == OP_KEY) && !item_reg.injected_event
                      && (item_reg.pressed_now || item_reg.pressed_before) && active;
    assign do_append  = key_live && item_reg.pressed_now && !item_reg.pressed_before
                        && (typed_count_reg < CNT_W'(MAX_SEQ_LEN));
    assign do_release = key_live && !item_reg.pressed_now;
    assign launch     = (state_reg == CTL_EXEC) && (do_append || do_release);
    assign count_inc  = typed_count_reg + 1'b1;
    assign idle_inc   = (idle_reg < timeout_reg) ? idle_reg + 8'd1 : idle_reg;
    assign wr_ok      = (32'(item_reg.entry_index) < DICT_ENTRIES)
                        && (32'(item_reg.slot_index) <= MAX_SEQ_LEN);
    assign wr_addr    = ADDR_W'(32'(item_reg.entry_index) * ENTRY_WORDS
                                + 32'(item_reg.slot_index));
    assign entry_wide = {{ENTRY_FIELD_W{1'b0}}, srch_entry};

    assign srch_req.go    = launch;
    assign srch_req.exact = do_release;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                state_next = launch ? CTL_WAIT : CTL_IDLE;
            end
            CTL_WAIT:
            begin
                if (srch_rsp.done)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next        = item_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        typed_keys_next  = typed_keys_reg;
        typed_count_next = typed_count_reg;
        idle_next        = idle_reg;
        wr_en            = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                end
            end
            CTL_EXEC:
            begin
                result_next = '0;
                done_next   = !launch;
                unique case (item_reg.operation)
                    OP_KEY:
                    begin
                        if (item_reg.injected_event)
                        begin
                            result_next.out_key = item_reg.key_code;
                        end
                        else if (!item_reg.pressed_now && !item_reg.pressed_before)
                        begin
                            result_next.out_key = leader ? '0 : item_reg.key_code;
                        end
                        else if (!active)
                        begin
                            if (!leader)
                            begin
                                result_next.out_key = item_reg.key_code;
                            end
                            else if (!item_reg.pressed_now)
                            begin
                                typed_count_next   = '0;
                                typed_keys_next[0] = item_reg.key_code;
                            end
                        end
                        else if (item_reg.pressed_now && !item_reg.pressed_before)
                        begin
                            if (do_append)
                            begin
                                typed_count_next           = count_inc;
                                idle_next                  = '0;
                                typed_keys_next[count_inc] = item_reg.key_code;
                            end
                            else
                            begin
                                typed_count_next    = '0;
                                idle_next           = '0;
                                typed_keys_next[0]  = '0;
                                result_next.out_key = item_reg.key_code;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        if (item_reg.post_clear && active)
                        begin
                            if (idle_inc >= timeout_reg)
                            begin
                                typed_count_next   = '0;
                                idle_next          = '0;
                                typed_keys_next[0] = '0;
                            end
                            else
                            begin
                                idle_next = idle_inc;
                            end
                        end
                    end
                    OP_WRITE:
                    begin
                        wr_en = wr_ok;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            CTL_WAIT:
            begin
                if (srch_rsp.done)
                begin
                    done_next                = 1'b1;
                    result_next.out_key      = srch_rsp.hit ? '0 : item_reg.key_code;
                    result_next.action_fired = do_release && srch_rsp.hit;
                    result_next.action_entry = (do_release && srch_rsp.hit)
                                               ? entry_wide[ENTRY_FIELD_W-1:0] : '0;
                    if (do_release || !srch_rsp.hit)
                    begin
                        typed_count_next   = '0;
                        idle_next          = '0;
                        typed_keys_next[0] = '0;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= CTL_IDLE;
            done_reg        <= 1'b0;
            typed_keys_reg  <= '0;
            typed_count_reg <= '0;
            idle_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            typed_keys_reg  <= typed_keys_next;
            typed_count_reg <= typed_count_next;
            idle_reg        <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            lead_low_reg  <= '0;
            lead_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TIMEOUT:   timeout_reg   <= pwdata[7:0];
                REG_LEAD_LOW:  lead_low_reg  <= pwdata[KEY_W-1:0];
                REG_LEAD_HIGH: lead_high_reg <= pwdata[KEY_W-1:0];
                default:       timeout_reg   <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIMEOUT:   prdata = {24'd0, timeout_reg};
            REG_LEAD_LOW:  prdata = {16'd0, lead_low_reg};
            REG_LEAD_HIGH: prdata = {16'd0, lead_high_reg};
            default:       prdata = '0;
        endcase
    end

    ksm_dict_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (KEY_W)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg.key_code),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ksm_search #(
        .MAX_SEQ_LEN  (MAX_SEQ_LEN),
        .DICT_ENTRIES (DICT_ENTRIES),
        .CNT_W        (CNT_W),
        .ENT_W        (ENT_W),
        .ADDR_W       (ADDR_W)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (srch_req),
        .typed_keys  (typed_keys_reg),
        .typed_count (typed_count_reg),
        .rsp         (srch_rsp),
        .hit_entry   (srch_entry),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    assign done   = done_reg;
    assign result = result_reg;

    `KSM_ASSERT_NEXT(a_busy_after_accept, accept, busy, "item taken but block not busy")
    `KSM_ASSERT_IMPL(a_fire_swallows, done && result.action_fired, result.out_key == '0, "fired item passed a key")
    `KSM_ASSERT_NEXT(a_scan_reported, (state_reg == CTL_WAIT) && srch_rsp.done, done && !busy, "scan result not delivered")
    `KSM_ASSERT_IMPL(a_count_bound, 1'b1, typed_count_reg <= CNT_W'(MAX_SEQ_LEN), "sequence count out of range")

endmodule

// File: sim/key_sequence_matcher_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the leader-key sequence matcher: command port, APB registers.
// Depends on ksm_pkg and key_sequence_matcher_unit; results are checked against a predictor.
module key_sequence_matcher_unit_tb;
    import ksm_pkg::*;

    localparam int SEQ_MAX   = MAX_SEQ_LEN_DEF;
    localparam int WORDS     = MAX_SEQ_LEN_DEF + 1;
    localparam int ENTRIES   = DICT_ENTRIES_DEF;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 130;
    localparam int IDLE_GAP  = 8;
    localparam int TAIL      = 250;
    localparam int LIMIT     = 4000;
    localparam int ITEM_W    = $bits(item_t);

    typedef struct packed {
        bit          is_reg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        item_t       it;
        bit          typed;
        result_t     want;
    } drow_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    item_t                item = '0;
    logic                 done;
    result_t              result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [7:0]  cfg_timeout = TIMEOUT_RESET;
    logic [15:0] cfg_lead_low = 16'h0000;
    logic [15:0] cfg_lead_high = 16'h0000;
    logic [15:0] seq_keys [WORDS] = '{default: 16'h0000};
    logic [2:0]  seq_len = 3'd0;
    logic [7:0]  idle_ticks = 8'd0;
    logic [15:0] dict_mem [ENTRIES*WORDS];

    result_t expected_results [$];
    drow_t   dir_rows [$];
    result_t want_now;
    int      fail_count = 0;
    int      items_sent = 0;
    int      burst_left = 0;
    int      stall_cycles = 0;

    key_sequence_matcher_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic logic is_lead(input logic [15:0] k);
        return k >= cfg_lead_low && k <= cfg_lead_high;
    endfunction

    function automatic logic [15:0] dict_word_at(input int e, input int s);
        if (e >= ENTRIES || s >= WORDS)
            return 16'h0000;
        return dict_mem[e*WORDS + s];
    endfunction

    function automatic void drop_sequence();
        idle_ticks = 8'd0;
        seq_len = 3'd0;
        seq_keys[0] = 16'h0000;
    endfunction

    function automatic int find_dict_match(input logic exact);
        int e;
        int i;
        int found;
        logic same;
        logic stop;
        found = -1;
        stop = 1'b0;
        for (e = 0; e < ENTRIES && found < 0 && !stop; e++)
        begin
            if (dict_word_at(e, 0) == 16'h0000)
                stop = 1'b1;
            else
            begin
                same = 1'b1;
                for (i = 0; i <= int'(seq_len) && i < WORDS; i++)
                    if (seq_keys[i] != dict_word_at(e, i))
                        same = 1'b0;
                if (same && (!exact || dict_word_at(e, int'(seq_len) + 1) == 16'h0000))
                    found = e;
            end
        end
        return found;
    endfunction

    function automatic result_t predict_result(input item_t it);
        result_t r;
        int hit;
        logic [15:0] k;
        r = '0;
        k = it.key_code;
        case (it.operation)
            OP_KEY:
            begin
                if (it.injected_event)
                    r.out_key = k;
                else if (!it.pressed_now && !it.pressed_before)
                    r.out_key = is_lead(k) ? 16'h0000 : k;
                else if (seq_keys[0] == 16'h0000)
                begin
                    if (!is_lead(k))
                        r.out_key = k;
                    else if (!it.pressed_now)
                    begin
                        seq_len = 3'd0;
                        seq_keys[0] = k;
                    end
                end
                else if (it.pressed_now && !it.pressed_before)
                begin
                    if (seq_len >= SEQ_MAX)
                    begin
                        drop_sequence();
                        r.out_key = k;
                    end
                    else
                    begin
                        seq_len = seq_len + 3'd1;
                        idle_ticks = 8'd0;
                        seq_keys[seq_len] = k;
                        if (find_dict_match(1'b0) < 0)
                        begin
                            drop_sequence();
                            r.out_key = k;
                        end
                    end
                end
                else if (!it.pressed_now)
                begin
                    hit = find_dict_match(1'b1);
                    drop_sequence();
                    if (hit < 0)
                        r.out_key = k;
                    else
                    begin
                        r.action_fired = 1'b1;
                        r.action_entry = hit[4:0];
                    end
                end
            end
            OP_TICK:
            begin
                if (it.post_clear && seq_keys[0] != 16'h0000)
                begin
                    if (idle_ticks < cfg_timeout)
                        idle_ticks = idle_ticks + 8'd1;
                    if (idle_ticks >= cfg_timeout)
                        drop_sequence();
                end
            end
            OP_WRITE:
            begin
                if (int'(it.entry_index) < ENTRIES && it.slot_index < WORDS)
                    dict_mem[int'(it.entry_index)*WORDS + int'(it.slot_index)] = it.key_code;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic item_t key_item(input logic [15:0] k, input logic down_now,
                                       input logic down_prev, input logic inj);
        item_t it;
        it = '0;
        it.operation = OP_KEY;
        it.key_code = k;
        it.pressed_now = down_now;
        it.pressed_before = down_prev;
        it.injected_event = inj;
        return it;
    endfunction

    function automatic item_t tick_item(input logic post);
        item_t it;
        it = '0;
        it.operation = OP_TICK;
        it.post_clear = post;
        return it;
    endfunction

    function automatic item_t write_item(input int e, input int s, input logic [15:0] w);
        item_t it;
        it = '0;
        it.operation = OP_WRITE;
        it.entry_index = ENTRY_FIELD_W'(e);
        it.slot_index = SLOT_FIELD_W'(s);
        it.key_code = w;
        return it;
    endfunction

    function automatic logic [15:0] alpha_key();
        return 16'(16'h0041 + $urandom_range(0, 7));
    endfunction

    function automatic result_t res(input logic [15:0] k, input logic f, input logic [4:0] e);
        result_t r;
        r.out_key = k;
        r.action_fired = f;
        r.action_entry = e;
        return r;
    endfunction

    function automatic drow_t row_item(input item_t it);
        drow_t r;
        r = '0;
        r.it = it;
        return r;
    endfunction

    function automatic drow_t row_want(input item_t it, input result_t want);
        drow_t r;
        r = '0;
        r.it = it;
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic drow_t row_reg(input logic [1:0] idx, input logic [31:0] val);
        drow_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_result(it));
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_TIMEOUT) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_TIMEOUT:   cfg_timeout = val[7:0];
            REG_LEAD_LOW:  cfg_lead_low = val[15:0];
            REG_LEAD_HIGH: cfg_lead_high = val[15:0];
            default: ;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_sequence();
        logic [15:0] keys [WORDS];
        int e;
        int n;
        int i;
        int extra;
        int ticks;
        e = $urandom_range(0, ENTRIES - 1);
        n = 0;
        extra = 0;
        for (i = 0; i < WORDS; i++)
            keys[i] = dict_word_at(e, i);
        while (n < SEQ_MAX && keys[n+1] != 16'h0000)
            n++;
        case ($urandom_range(0, 9))
            0: keys[0] = 16'(16'h00FE + $urandom_range(0, 7));
            1: if (n > 0) keys[$urandom_range(1, n)] = alpha_key();
            2: extra = $urandom_range(1, 2);
            3: n = $urandom_range(0, n);
            default: ;
        endcase
        if ($urandom_range(0, 1))
            send_item(key_item(keys[0], 1'b1, 1'b0, 1'b0));
        send_item(key_item(keys[0], 1'b0, 1'b1, 1'b0));
        for (i = 1; i <= n + extra; i++)
        begin
            case ($urandom_range(0, 11))
                0: send_item(tick_item(1'($urandom_range(0, 1))));
                1: send_item(key_item(16'($urandom), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 1'b1));
                2: send_item(key_item($urandom_range(0, 1) ? alpha_key() : keys[0],
                                      1'b0, 1'b0, 1'b0));
                default: ;
            endcase
            send_item(key_item(i <= n ? keys[i] : alpha_key(), 1'b1, 1'b0, 1'b0));
            if ($urandom_range(0, 3) == 0)
                send_item(key_item(i <= n ? keys[i] : alpha_key(), 1'b1, 1'b1, 1'b0));
        end
        if ((cfg_timeout <= 16 && $urandom_range(0, 4) == 0) || $urandom_range(0, 39) == 0)
        begin
            ticks = int'(cfg_timeout) + int'($urandom_range(0, 2)) - 1;
            for (i = 0; i < ticks; i++)
                send_item(tick_item(1'b1));
        end
        if ($urandom_range(0, 9) != 0)
            send_item(key_item(keys[n], 1'b0, 1'b1, 1'b0));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(result), 32'd0);
            else
            begin
                want_now = expected_results.pop_front();
                if (result.out_key !== want_now.out_key)
                    report_mismatch("out_key", 32'(result.out_key), 32'(want_now.out_key));
                if (result.action_fired !== want_now.action_fired)
                    report_mismatch("action_fired", 32'(result.action_fired),
                                    32'(want_now.action_fired));
                if (result.action_entry !== want_now.action_entry)
                    report_mismatch("action_entry", 32'(result.action_entry),
                                    32'(want_now.action_entry));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int e;
        int s;
        int i;
        int p;
        int len;
        int phase_end;
        logic [15:0] w;
        logic [7:0] ph_to;
        logic [15:0] ph_lo;
        logic [15:0] ph_hi;
        logic [ITEM_W-1:0] raw;
        item_t all_ones;
        item_t it;
        drow_t r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every word so that no lookup ever touches an unwritten entry
        for (e = 0; e < ENTRIES; e++)
        begin
            len = $urandom_range(1, SEQ_MAX);
            for (s = 0; s < WORDS; s++)
            begin
                if (e == 0)
                    w = (s == 0) ? 16'h0100 : (s == 1) ? 16'h0041 : 16'h0000;
                else if (e == ENTRIES - 1)
                    w = (s == 0) ? 16'h0100 : 16'(16'h0041 + s);
                else if (s == 0)
                    w = 16'(16'h0100 + $urandom_range(0, 3));
                else if (s == 1)
                    w = 16'(16'h0043 + $urandom_range(0, 5));
                else if (s <= len)
                    w = alpha_key();
                else
                    w = 16'h0000;
                send_item(write_item(e, s, w));
            end
        end

        all_ones = '1;
        dir_rows.push_back(row_want(key_item(16'hFFFF, 1'b0, 1'b0, 1'b0),
                                    res(16'hFFFF, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(key_item(16'h0000, 1'b0, 1'b0, 1'b0),
                                    res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(key_item(16'h0000, 1'b0, 1'b1, 1'b0),
                                    res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(key_item(16'h0041, 1'b1, 1'b0, 1'b0),
                                    res(16'h0041, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(tick_item(1'b1), res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(all_ones, res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(write_item(ENTRIES - 1, 7, 16'hABCD),
                                    res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_reg(REG_LEAD_LOW, 32'h0000_0100));
        dir_rows.push_back(row_reg(REG_LEAD_HIGH, 32'h0000_0100));
        dir_rows.push_back(row_want(key_item(16'h0100, 1'b1, 1'b0, 1'b0),
                                    res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(key_item(16'h0100, 1'b0, 1'b1, 1'b0),
                                    res(16'h0000, 1'b0, 5'd0)));
        dir_rows.push_back(row_want(key_item(16'h0100, 1'b1, 1'b1, 1'b1),
                                    res(16'h0100, 1'b0, 5'd0)));
        dir_rows.push_back(row_item(key_item(16'h0041, 1'b1, 1'b0, 1'b0)));
        dir_rows.push_back(row_item(key_item(16'h0041, 1'b1, 1'b1, 1'b0)));
        dir_rows.push_back(row_want(key_item(16'h0041, 1'b0, 1'b1, 1'b0),
                                    res(16'h0000, 1'b1, 5'd0)));
        dir_rows.push_back(row_item(key_item(16'h0100, 1'b0, 1'b1, 1'b0)));
        for (i = 2; i <= 5; i++)
            dir_rows.push_back(row_item(key_item(16'(16'h0040 + i), 1'b1, 1'b0, 1'b0)));
        dir_rows.push_back(row_want(key_item(16'h0045, 1'b0, 1'b1, 1'b0),
                                    res(16'h0000, 1'b1, 5'd31)));
        dir_rows.push_back(row_reg(REG_TIMEOUT, 32'h0000_0000));
        dir_rows.push_back(row_item(key_item(16'h0100, 1'b0, 1'b1, 1'b0)));
        dir_rows.push_back(row_item(tick_item(1'b0)));
        dir_rows.push_back(row_item(tick_item(1'b1)));
        dir_rows.push_back(row_item(key_item(16'h0041, 1'b1, 1'b0, 1'b0)));
        dir_rows.push_back(row_reg(REG_LEAD_LOW, 32'h0000_0101));
        dir_rows.push_back(row_want(key_item(16'h0100, 1'b0, 1'b0, 1'b0),
                                    res(16'h0100, 1'b0, 5'd0)));

        for (i = 0; i < dir_rows.size(); i++)
        begin
            r = dir_rows[i];
            if (r.is_reg)
            begin
                drain_results();
                program_reg(r.reg_idx, r.reg_val);
            end
            else
            begin
                send_item(r.it);
                if (r.typed)
                    expected_results[expected_results.size() - 1] = r.want;
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin ph_to = 8'd80;  ph_lo = 16'h0100; ph_hi = 16'h0103; end
                1: begin ph_to = 8'd1;   ph_lo = 16'h0100; ph_hi = 16'h0103; end
                2: begin ph_to = 8'd255; ph_lo = 16'h0100; ph_hi = 16'h0103; end
                3: begin ph_to = 8'd0;   ph_lo = 16'h0100; ph_hi = 16'h0101; end
                4: begin ph_to = 8'd4;   ph_lo = 16'h0000; ph_hi = 16'hFFFF; end
                5: begin ph_to = 8'd6;   ph_lo = 16'h0103; ph_hi = 16'h0100; end
                6:
                begin
                    ph_to = 8'($urandom_range(1, 20));
                    ph_lo = 16'h0100;
                    ph_hi = 16'(16'h0100 + $urandom_range(0, 3));
                end
                default: begin ph_to = 8'd2; ph_lo = 16'h0102; ph_hi = 16'h0102; end
            endcase
            drain_results();
            program_reg(REG_TIMEOUT, {24'd0, ph_to});
            program_reg(REG_LEAD_LOW, {16'd0, ph_lo});
            program_reg(REG_LEAD_HIGH, {16'd0, ph_hi});
            phase_end = items_sent + PER_PHASE;
            while (items_sent < phase_end)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:
                    begin
                        raw = ITEM_W'($urandom);
                        it = raw;
                        it.operation = 2'($urandom_range(0, 3));
                        send_item(it);
                    end
                    4:
                    begin
                        w = $urandom_range(0, 7) == 0 ? 16'h0000 : alpha_key();
                        send_item(write_item($urandom_range(0, ENTRIES - 1),
                                             $urandom_range(1, SEQ_MAX), w));
                    end
                    default: run_sequence();
                endcase
            end
        end

        drain_results();
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
